// File: hw/rtl/pfa_pkg.sv
// Shared constants, codes and types of the partition fit allocator.
package pfa_pkg;

   localparam int SLOTS     = 4;
   localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SIZE_W    = 31;
   localparam int HDR_W     = 16;
   localparam int TAG_W     = 64;
   localparam int CUR_W     = SIZE_W + 1;
   localparam int STATUS_W  = 3;
   localparam int FIT_W     = 2;
   localparam int IDX_OUT_W = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DISK_SIZE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTES = 1'd1;

   localparam logic [HDR_W-1:0] HEADER_RESET = 16'd120;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_NO_FREE    = 3'd1,
      ST_EXT_EXISTS = 3'd2,
      ST_DUP_NAME   = 3'd3,
      ST_NO_SPACE   = 3'd4
   } status_type;

   typedef struct packed {
      logic              used;
      logic              ext;
      logic [SIZE_W-1:0] start;
      logic [SIZE_W-1:0] len;
      logic [TAG_W-1:0]  tag;
   } slot_rd_type;

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] idx;
      logic              ext;
      logic [SIZE_W-1:0] start;
      logic [SIZE_W-1:0] len;
      logic [TAG_W-1:0]  tag;
   } slot_wr_type;

   typedef struct packed {
      logic              clear;
      logic              update;
      logic [FIT_W-1:0]  fit;
      logic [SIZE_W-1:0] want;
      logic [SIZE_W-1:0] gap_start;
      logic [SIZE_W-1:0] gap_len;
   } fit_ctl_type;

   typedef struct packed {
      logic              chosen;
      logic [SIZE_W-1:0] chosen_start;
      logic [SIZE_W-1:0] largest;
   } fit_res_type;

endpackage

// File: hw/rtl/pfa_slot_store.sv
// Region slot table: one read port, one write port, used bits cleared on reset.
module pfa_slot_store (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [pfa_pkg::SLOT_W-1:0]  rd_idx,
   input  pfa_pkg::slot_wr_type        wr,
   output pfa_pkg::slot_rd_type        rd,
   output logic [pfa_pkg::SLOTS-1:0]   used_vec
);

   logic [pfa_pkg::SLOTS-1:0]  used_ff;
   logic [pfa_pkg::SLOTS-1:0]  ext_ff;
   logic [pfa_pkg::SIZE_W-1:0] start_ff [pfa_pkg::SLOTS];
   logic [pfa_pkg::SIZE_W-1:0] len_ff   [pfa_pkg::SLOTS];
   logic [pfa_pkg::TAG_W-1:0]  tag_ff   [pfa_pkg::SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (wr.we) begin
         used_ff[wr.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we) begin
         ext_ff[wr.idx]   <= wr.ext;
         start_ff[wr.idx] <= wr.start;
         len_ff[wr.idx]   <= wr.len;
         tag_ff[wr.idx]   <= wr.tag;
      end
   end

   always_comb begin
      rd.used  = used_ff[rd_idx];
      rd.ext   = ext_ff[rd_idx];
      rd.start = start_ff[rd_idx];
      rd.len   = len_ff[rd_idx];
      rd.tag   = tag_ff[rd_idx];
   end

   assign used_vec = used_ff;

endmodule

// File: hw/rtl/pfa_fit_track.sv
// Gap evaluator: tracks the largest gap and the gap chosen by the fit policy.
module pfa_fit_track (
   input  logic                 clock,
   input  pfa_pkg::fit_ctl_type ctl,
   output pfa_pkg::fit_res_type res
);

   logic                       chosen_ff, chosen_in;
   logic [pfa_pkg::SIZE_W-1:0] chosen_start_ff, chosen_start_in;
   logic [pfa_pkg::SIZE_W-1:0] chosen_len_ff, chosen_len_in;
   logic [pfa_pkg::SIZE_W-1:0] largest_ff, largest_in;
   logic                       fits;
   logic                       take;

   always_comb begin
      fits = ctl.gap_len >= ctl.want;
      case (ctl.fit)
         pfa_pkg::FIT_FIRST: take = fits && !chosen_ff;
         pfa_pkg::FIT_BEST:  take = fits && (!chosen_ff || ctl.gap_len < chosen_len_ff);
         pfa_pkg::FIT_WORST: take = !chosen_ff || ctl.gap_len > chosen_len_ff;
         default:            take = 1'b0;
      endcase

      chosen_in       = chosen_ff;
      chosen_start_in = chosen_start_ff;
      chosen_len_in   = chosen_len_ff;
      largest_in      = largest_ff;
      if (ctl.clear) begin
         chosen_in       = 1'b0;
         chosen_start_in = '0;
         chosen_len_in   = '0;
         largest_in      = '0;
      end else if (ctl.update) begin
         if (ctl.gap_len > largest_ff) begin
            largest_in = ctl.gap_len;
         end
         if (take) begin
            chosen_in       = 1'b1;
            chosen_start_in = ctl.gap_start;
            chosen_len_in   = ctl.gap_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      chosen_ff       <= chosen_in;
      chosen_start_ff <= chosen_start_in;
      chosen_len_ff   <= chosen_len_in;
      largest_ff      <= largest_in;
   end

   assign res.chosen       = chosen_ff;
   assign res.chosen_start = chosen_start_ff;
   assign res.largest      = largest_ff;

endmodule

// File: hw/rtl/partition_fit_allocator.sv
// Partition fit allocator top level: request sequencer, slot table and gap evaluator.
// A request word is taken only while the block is idle and yields one response word.
// The sequencer walks the slot table through its single read port, one slot per cycle:
// a check pass over all SLOTS slots, then for each used region and once more for the
// tail gap a selection pass over all SLOTS slots followed by a gap state and a fit state.
// A request that passes the check then goes through a resolve state to the output state,
// where its response is offered; a refusal from the check pass goes from the check-end
// state straight to the output state.
// The response register frees the request side as soon as a response is loaded.
module partition_fit_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_part_type,
   input  logic [pfa_pkg::FIT_W-1:0]       req_fit_mode,
   input  logic [pfa_pkg::SIZE_W-1:0]      req_size_bytes,
   input  logic [pfa_pkg::TAG_W-1:0]       req_name_tag,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pfa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [pfa_pkg::SIZE_W-1:0]      rsp_region_start,
   output logic [pfa_pkg::IDX_OUT_W-1:0]   rsp_slot_index,
   output logic [pfa_pkg::SIZE_W-1:0]      rsp_largest_gap,
   input  logic                            csr_write,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pfa_pkg::SIZE_W-1:0]      csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_CHECK_END,
      S_SCAN,
      S_GAP,
      S_FIT,
      S_RESOLVE,
      S_OUT
   } state_type;

   localparam logic [pfa_pkg::SLOT_W-1:0] LAST_IDX = pfa_pkg::SLOT_W'(pfa_pkg::SLOTS - 1);

   state_type                         state_ff;
   logic [pfa_pkg::SIZE_W-1:0]        disk_ff;
   logic [pfa_pkg::HDR_W-1:0]         header_ff;

   logic                              ext_ff;
   logic [pfa_pkg::FIT_W-1:0]         fit_ff;
   logic [pfa_pkg::SIZE_W-1:0]        want_ff;
   logic [pfa_pkg::TAG_W-1:0]         tag_ff;

   logic [pfa_pkg::SLOT_W-1:0]        idx_ff;
   logic                              free_found_ff;
   logic [pfa_pkg::SLOT_W-1:0]        free_slot_ff;
   pfa_pkg::status_type               viol_ff;

   logic                              last_valid_ff;
   logic [pfa_pkg::SIZE_W-1:0]        last_start_ff;
   logic [pfa_pkg::SLOT_W-1:0]        last_idx_ff;
   logic                              best_found_ff;
   logic [pfa_pkg::SIZE_W-1:0]        best_start_ff;
   logic [pfa_pkg::SIZE_W-1:0]        best_len_ff;
   logic [pfa_pkg::SLOT_W-1:0]        best_idx_ff;

   logic [pfa_pkg::CUR_W-1:0]         cursor_ff;
   logic                              gap_ok_ff;
   logic [pfa_pkg::SIZE_W-1:0]        gap_start_ff;
   logic [pfa_pkg::SIZE_W-1:0]        gap_len_ff;
   logic                              tail_ff;

   pfa_pkg::status_type               res_status_ff;
   logic [pfa_pkg::SIZE_W-1:0]        res_start_ff;
   logic [pfa_pkg::IDX_OUT_W-1:0]     res_slot_ff;
   logic [pfa_pkg::SIZE_W-1:0]        res_largest_ff;

   logic                              rsp_valid_ff;
   pfa_pkg::status_type               rsp_status_ff;
   logic [pfa_pkg::SIZE_W-1:0]        rsp_start_ff;
   logic [pfa_pkg::IDX_OUT_W-1:0]     rsp_slot_ff;
   logic [pfa_pkg::SIZE_W-1:0]        rsp_largest_ff;

   pfa_pkg::slot_rd_type              slot_rd;
   pfa_pkg::slot_wr_type              slot_wr;
   logic [pfa_pkg::SLOTS-1:0]         used_vec;
   pfa_pkg::fit_ctl_type              fit_ctl;
   pfa_pkg::fit_res_type              fit_res;

   logic                              req_take;
   logic                              cand;
   logic                              place_ok;

   pfa_slot_store u_slots (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (idx_ff),
      .wr       (slot_wr),
      .rd       (slot_rd),
      .used_vec (used_vec)
   );

   pfa_fit_track u_fit (
      .clock (clock),
      .ctl   (fit_ctl),
      .res   (fit_res)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   // next region in (start, slot) order after the last one placed on the cursor
   assign cand = slot_rd.used &&
                 (!last_valid_ff || slot_rd.start > last_start_ff ||
                  (slot_rd.start == last_start_ff && idx_ff > last_idx_ff));

   assign place_ok = fit_res.chosen && !(fit_res.largest < want_ff);

   always_comb begin
      fit_ctl.clear     = req_take;
      fit_ctl.update    = (state_ff == S_FIT) && gap_ok_ff;
      fit_ctl.fit       = fit_ff;
      fit_ctl.want      = want_ff;
      fit_ctl.gap_start = gap_start_ff;
      fit_ctl.gap_len   = gap_len_ff;

      slot_wr.we    = (state_ff == S_RESOLVE) && place_ok;
      slot_wr.idx   = free_slot_ff;
      slot_wr.ext   = ext_ff;
      slot_wr.start = fit_res.chosen_start;
      slot_wr.len   = want_ff;
      slot_wr.tag   = tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         disk_ff      <= '0;
         header_ff    <= pfa_pkg::HEADER_RESET;
      end else begin
         if (csr_write) begin
            case (csr_index)
               pfa_pkg::CSR_DISK_SIZE:    disk_ff   <= csr_data;
               pfa_pkg::CSR_HEADER_BYTES: header_ff <= csr_data[pfa_pkg::HDR_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ext_ff        <= req_part_type;
                  fit_ff        <= req_fit_mode;
                  want_ff       <= req_size_bytes;
                  tag_ff        <= req_name_tag;
                  idx_ff        <= '0;
                  free_found_ff <= 1'b0;
                  viol_ff       <= pfa_pkg::ST_OK;
                  state_ff      <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (!slot_rd.used && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_slot_ff  <= idx_ff;
               end
               if (slot_rd.used && viol_ff == pfa_pkg::ST_OK) begin
                  if (ext_ff && slot_rd.ext) begin
                     viol_ff <= pfa_pkg::ST_EXT_EXISTS;
                  end else if (slot_rd.tag == tag_ff) begin
                     viol_ff <= pfa_pkg::ST_DUP_NAME;
                  end
               end
               if (idx_ff == LAST_IDX) begin
                  state_ff <= S_CHECK_END;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_CHECK_END: begin
               res_start_ff   <= '0;
               res_slot_ff    <= '0;
               res_largest_ff <= '0;
               if (!free_found_ff) begin
                  res_status_ff <= pfa_pkg::ST_NO_FREE;
                  state_ff      <= S_OUT;
               end else if (viol_ff != pfa_pkg::ST_OK) begin
                  res_status_ff <= viol_ff;
                  state_ff      <= S_OUT;
               end else begin
                  cursor_ff     <= pfa_pkg::CUR_W'(header_ff);
                  last_valid_ff <= 1'b0;
                  best_found_ff <= 1'b0;
                  idx_ff        <= '0;
                  state_ff      <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (cand && (!best_found_ff || slot_rd.start < best_start_ff)) begin
                  best_found_ff <= 1'b1;
                  best_start_ff <= slot_rd.start;
                  best_len_ff   <= slot_rd.len;
                  best_idx_ff   <= idx_ff;
               end
               if (idx_ff == LAST_IDX) begin
                  state_ff <= S_GAP;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_GAP: begin
               gap_start_ff <= cursor_ff[pfa_pkg::SIZE_W-1:0];
               if (best_found_ff) begin
                  gap_ok_ff     <= cursor_ff < {1'b0, best_start_ff};
                  gap_len_ff    <= best_start_ff - cursor_ff[pfa_pkg::SIZE_W-1:0];
                  cursor_ff     <= {1'b0, best_start_ff} + {1'b0, best_len_ff};
                  last_valid_ff <= 1'b1;
                  last_start_ff <= best_start_ff;
                  last_idx_ff   <= best_idx_ff;
                  best_found_ff <= 1'b0;
                  idx_ff        <= '0;
                  tail_ff       <= 1'b0;
               end else begin
                  gap_ok_ff  <= cursor_ff < {1'b0, disk_ff};
                  gap_len_ff <= disk_ff - cursor_ff[pfa_pkg::SIZE_W-1:0];
                  tail_ff    <= 1'b1;
               end
               state_ff <= S_FIT;
            end
            S_FIT: begin
               state_ff <= tail_ff ? S_RESOLVE : S_SCAN;
            end
            S_RESOLVE: begin
               res_largest_ff <= fit_res.largest;
               if (place_ok) begin
                  res_status_ff <= pfa_pkg::ST_OK;
                  res_start_ff  <= fit_res.chosen_start;
                  res_slot_ff   <= pfa_pkg::IDX_OUT_W'(free_slot_ff);
               end else begin
                  res_status_ff <= pfa_pkg::ST_NO_SPACE;
                  res_start_ff  <= '0;
                  res_slot_ff   <= '0;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= res_status_ff;
                  rsp_start_ff   <= res_start_ff;
                  rsp_slot_ff    <= res_slot_ff;
                  rsp_largest_ff <= res_largest_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_region_start = rsp_start_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_largest_gap  = rsp_largest_ff;

   a_write_free: assert property (@(posedge clock) disable iff (reset)
      slot_wr.we |-> !used_vec[slot_wr.idx])
      else $error("region written into a used slot");

   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != pfa_pkg::ST_OK) |->
         (rsp_start_ff == '0 && rsp_slot_ff == '0))
      else $error("refused word carries a placement");

   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      slot_wr.we |=> $countones(used_vec) == $past($countones(used_vec)) + 1)
      else $error("slot fill count did not advance by one");

endmodule

// File: tb/sv/tb_partition_fit_allocator.sv
// Testbench for partition_fit_allocator: directed and random traffic checked against a slot table model.
`timescale 1ns / 100ps

module tb_partition_fit_allocator;

   localparam logic [pfa_pkg::FIT_W-1:0]  FIT_UNUSED = 2'd3;
   localparam logic [pfa_pkg::SIZE_W-1:0] SIZE_MAX   = 31'h7FFF_FFFF;
   localparam int                         LIMIT      = 1000000;
   localparam int                         PHASES     = 16;
   localparam int                         PHASE_LEN  = 96;

   typedef struct {
      logic                       ext;
      logic [pfa_pkg::FIT_W-1:0]  fit;
      logic [pfa_pkg::SIZE_W-1:0] size;
      logic [pfa_pkg::TAG_W-1:0]  tag;
   } alloc_req_type;

   typedef struct {
      pfa_pkg::status_type           status;
      logic [pfa_pkg::SIZE_W-1:0]    start;
      logic [pfa_pkg::IDX_OUT_W-1:0] slot;
      logic [pfa_pkg::SIZE_W-1:0]    big;
   } alloc_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_part_type = 1'b0;
   logic [pfa_pkg::FIT_W-1:0]     req_fit_mode = '0;
   logic [pfa_pkg::SIZE_W-1:0]    req_size_bytes = '0;
   logic [pfa_pkg::TAG_W-1:0]     req_name_tag = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b1;
   logic [pfa_pkg::STATUS_W-1:0]  rsp_status;
   logic [pfa_pkg::SIZE_W-1:0]    rsp_region_start;
   logic [pfa_pkg::IDX_OUT_W-1:0] rsp_slot_index;
   logic [pfa_pkg::SIZE_W-1:0]    rsp_largest_gap;
   logic                          csr_write = 1'b0;
   logic [pfa_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pfa_pkg::SIZE_W-1:0]    csr_data = '0;

   partition_fit_allocator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_part_type    (req_part_type),
      .req_fit_mode     (req_fit_mode),
      .req_size_bytes   (req_size_bytes),
      .req_name_tag     (req_name_tag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_region_start (rsp_region_start),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_largest_gap  (rsp_largest_gap),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // allocator shadow state
   logic                       slot_used [pfa_pkg::SLOTS];
   logic                       slot_ext  [pfa_pkg::SLOTS];
   logic [pfa_pkg::SIZE_W-1:0] slot_start[pfa_pkg::SLOTS];
   logic [pfa_pkg::SIZE_W-1:0] slot_len  [pfa_pkg::SLOTS];
   logic [pfa_pkg::TAG_W-1:0]  slot_tag  [pfa_pkg::SLOTS];
   logic [pfa_pkg::SIZE_W-1:0] disk_q = '0;
   logic [pfa_pkg::HDR_W-1:0]  hdr_q  = pfa_pkg::HEADER_RESET;
   longint                     gap_lo [pfa_pkg::SLOTS+1];
   longint                     gap_len[pfa_pkg::SLOTS+1];
   int                         gap_n;

   alloc_req_type alloc_req_q[$];
   alloc_rsp_type alloc_rsp_q[$];
   alloc_req_type nxt_req;
   alloc_rsp_type pred_rsp;
   alloc_rsp_type want;

   int errors = 0;
   int rsp_seen = 0;
   int cyc = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   int next_hold = 300;

   initial begin
      for (int i = 0; i < pfa_pkg::SLOTS; i++) begin
         slot_used[i] = 1'b0;
         slot_ext[i] = 1'b0;
         slot_start[i] = '0;
         slot_len[i] = '0;
         slot_tag[i] = '0;
      end
   end

   // free gaps between header end and disk end; returns the largest
   function automatic longint scan_gaps();
      int     ord[pfa_pkg::SLOTS];
      int     nu;
      int     j;
      longint cur;
      longint s;
      longint big;
      nu = 0;
      for (int i = 0; i < pfa_pkg::SLOTS; i++) begin
         if (slot_used[i]) begin
            j = nu;
            while (j > 0 && slot_start[ord[j-1]] > slot_start[i]) begin
               ord[j] = ord[j-1];
               j--;
            end
            ord[j] = i;
            nu++;
         end
      end
      cur = longint'(hdr_q);
      gap_n = 0;
      for (int i = 0; i < nu; i++) begin
         s = longint'(slot_start[ord[i]]);
         if (cur < s) begin
            gap_lo[gap_n] = cur;
            gap_len[gap_n] = s - cur;
            gap_n++;
         end
         cur = s + longint'(slot_len[ord[i]]);
      end
      if (cur < longint'(disk_q)) begin
         gap_lo[gap_n] = cur;
         gap_len[gap_n] = longint'(disk_q) - cur;
         gap_n++;
      end
      big = 0;
      for (int i = 0; i < gap_n; i++)
         if (gap_len[i] > big) big = gap_len[i];
      return big;
   endfunction

   function automatic alloc_rsp_type predict_alloc(alloc_req_type r);
      alloc_rsp_type o;
      int            free_i;
      int            pick;
      longint        big;
      o.status = pfa_pkg::ST_OK;
      o.start = '0;
      o.slot = '0;
      o.big = '0;
      free_i = -1;
      for (int i = pfa_pkg::SLOTS - 1; i >= 0; i--)
         if (!slot_used[i]) free_i = i;
      if (free_i < 0) begin
         o.status = pfa_pkg::ST_NO_FREE;
         return o;
      end
      for (int i = 0; i < pfa_pkg::SLOTS; i++) begin
         if (slot_used[i]) begin
            if (r.ext && slot_ext[i]) begin
               o.status = pfa_pkg::ST_EXT_EXISTS;
               return o;
            end
            if (slot_tag[i] == r.tag) begin
               o.status = pfa_pkg::ST_DUP_NAME;
               return o;
            end
         end
      end
      big = scan_gaps();
      o.big = big[pfa_pkg::SIZE_W-1:0];
      pick = -1;
      if (big >= longint'(r.size)) begin
         case (r.fit)
            pfa_pkg::FIT_FIRST: begin
               for (int i = gap_n - 1; i >= 0; i--)
                  if (gap_len[i] >= longint'(r.size)) pick = i;
            end
            pfa_pkg::FIT_BEST: begin
               for (int i = 0; i < gap_n; i++)
                  if (gap_len[i] >= longint'(r.size) &&
                      (pick < 0 || gap_len[i] < gap_len[pick]))
                     pick = i;
            end
            pfa_pkg::FIT_WORST: begin
               for (int i = 0; i < gap_n; i++)
                  if (pick < 0 || gap_len[i] > gap_len[pick]) pick = i;
            end
            default: pick = -1;
         endcase
      end
      if (pick < 0) begin
         o.status = pfa_pkg::ST_NO_SPACE;
         return o;
      end
      slot_used[free_i] = 1'b1;
      slot_ext[free_i] = r.ext;
      slot_start[free_i] = gap_lo[pick][pfa_pkg::SIZE_W-1:0];
      slot_len[free_i] = r.size;
      slot_tag[free_i] = r.tag;
      o.start = gap_lo[pick][pfa_pkg::SIZE_W-1:0];
      o.slot = free_i[pfa_pkg::IDX_OUT_W-1:0];
      return o;
   endfunction

   task automatic add_req(input logic e, input logic [pfa_pkg::FIT_W-1:0] f,
                          input logic [pfa_pkg::SIZE_W-1:0] s,
                          input logic [pfa_pkg::TAG_W-1:0] t);
      alloc_req_type r;
      r.ext = e;
      r.fit = f;
      r.size = s;
      r.tag = t;
      alloc_req_q = {alloc_req_q, r};
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (alloc_req_q.size() != 0 || req_valid || alloc_rsp_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic [pfa_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pfa_pkg::SIZE_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == pfa_pkg::CSR_DISK_SIZE)
         disk_q = val;
      else
         hdr_q = val[pfa_pkg::HDR_W-1:0];
   endtask

   // sender: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            nxt_req.ext = req_part_type;
            nxt_req.fit = req_fit_mode;
            nxt_req.size = req_size_bytes;
            nxt_req.tag = req_name_tag;
            pred_rsp = predict_alloc(nxt_req);
            alloc_rsp_q = {alloc_rsp_q, pred_rsp};
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               req_valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (alloc_req_q.size() != 0) begin
               nxt_req = alloc_req_q.pop_front();
               req_valid <= 1'b1;
               req_part_type <= nxt_req.ext;
               req_fit_mode <= nxt_req.fit;
               req_size_bytes <= nxt_req.size;
               req_name_tag <= nxt_req.tag;
               if (burst_left <= 1) begin
                  burst_left <= ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 8);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern steps through four modes, plus long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (rsp_seen >= next_hold) begin
         rsp_stall <= 1'b1;
         hold_left <= 400;
         next_hold <= next_hold + 700;
      end else begin
         case ((cyc >> 7) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            2: rsp_stall <= ($urandom_range(0, 9) != 0);
            default: rsp_stall <= (cyc % 3 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen <= rsp_seen + 1;
         if (alloc_rsp_q.size() == 0) begin
            errors <= errors + 1;
            if (errors < 10)
               $display("unexpected word: status %0d start %0d slot %0d gap %0d",
                        rsp_status, rsp_region_start, rsp_slot_index, rsp_largest_gap);
         end else begin
            want = alloc_rsp_q.pop_front();
            if (rsp_status !== want.status || rsp_region_start !== want.start ||
                rsp_slot_index !== want.slot || rsp_largest_gap !== want.big) begin
               errors <= errors + 1;
               if (errors < 10)
                  $display("mismatch: got %0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d",
                           rsp_status, rsp_region_start, rsp_slot_index, rsp_largest_gap,
                           want.status, want.start, want.slot, want.big);
            end
         end
      end
   end

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc == LIMIT) begin
         $display("tb_partition_fit_allocator NOT OK");
         $finish;
      end
   end

   initial begin
      alloc_req_type              r;
      longint                     big;
      int                         nfree;
      int                         nused;
      int                         cand;
      int                         kind;
      int                         pick;
      logic                       any_ext;
      logic [pfa_pkg::SIZE_W-1:0] dsz;
      logic [pfa_pkg::SIZE_W-1:0] hsz;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset config: nothing to allocate
      add_req(1'b0, pfa_pkg::FIT_FIRST, 31'd1, 64'h0);
      add_req(1'b0, pfa_pkg::FIT_BEST, 31'd0, 64'h1);
      add_req(1'b1, pfa_pkg::FIT_WORST, SIZE_MAX, 64'hFFFF_FFFF_FFFF_FFFF);
      wait_idle();
      write_csr(pfa_pkg::CSR_DISK_SIZE, SIZE_MAX);
      write_csr(pfa_pkg::CSR_HEADER_BYTES, SIZE_MAX);
      add_req(1'b1, FIT_UNUSED, 31'd1, 64'hA5A5_0000_0000_0001);
      add_req(1'b0, pfa_pkg::FIT_BEST, SIZE_MAX, 64'hA5A5_0000_0000_0001);
      add_req(1'b1, pfa_pkg::FIT_FIRST, 31'd100, 64'h8000_0000_0000_0E01);
      add_req(1'b1, pfa_pkg::FIT_WORST, 31'd1, 64'h0000_0000_0000_0B01);
      add_req(1'b0, pfa_pkg::FIT_FIRST, 31'd1, 64'h8000_0000_0000_0E01);
      add_req(1'b1, pfa_pkg::FIT_BEST, 31'd5, 64'h8000_0000_0000_0E01);
      wait_idle();
      // header drops below the region: gap opens in front of it
      write_csr(pfa_pkg::CSR_HEADER_BYTES, 31'd0);
      add_req(1'b0, pfa_pkg::FIT_BEST, 31'd1000, 64'h5A5A_0000_0000_0001);
      add_req(1'b0, FIT_UNUSED, 31'd0, 64'h5A5A_0000_0000_0002);
      wait_idle();
      // two equal gaps for worst fit
      write_csr(pfa_pkg::CSR_DISK_SIZE, 31'd130170);
      add_req(1'b0, pfa_pkg::FIT_WORST, 31'd5, 64'h5A5A_0000_0000_0003);
      add_req(1'b0, pfa_pkg::FIT_FIRST, 31'd64536, 64'h5A5A_0000_0000_0004);
      add_req(1'b0, pfa_pkg::FIT_BEST, 31'd1, 64'h5A5A_0000_0000_0001);

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         case ($urandom_range(0, 4))
            0: dsz = '0;
            1: dsz = SIZE_MAX;
            2: dsz = 31'($urandom);
            3: dsz = 31'($urandom_range(60000, 200000));
            default: dsz = 31'($urandom_range(0, 140000));
         endcase
         case ($urandom_range(0, 3))
            0: hsz = '0;
            1: hsz = 31'($urandom);
            2: hsz = 31'($urandom_range(0, 2000));
            default: hsz = SIZE_MAX;
         endcase
         if (ph == 0) begin
            dsz = '0;
            hsz = '0;
         end else if (ph == 1) begin
            dsz = SIZE_MAX;
            hsz = SIZE_MAX;
         end
         write_csr(pfa_pkg::CSR_DISK_SIZE, dsz);
         write_csr(pfa_pkg::CSR_HEADER_BYTES, hsz);

         big = scan_gaps();
         nfree = 0;
         nused = 0;
         any_ext = 1'b0;
         for (int i = 0; i < pfa_pkg::SLOTS; i++) begin
            if (slot_used[i]) begin
               nused++;
               if (slot_ext[i]) any_ext = 1'b1;
            end else begin
               nfree++;
            end
         end
         cand = (ph == 7 || ph == 12) ? $urandom_range(0, PHASE_LEN - 1) : -1;

         for (int k = 0; k < PHASE_LEN; k++) begin
            r.ext = 1'($urandom_range(0, 1));
            r.fit = 2'($urandom_range(0, 2));
            r.size = 31'($urandom);
            r.tag = {$urandom, $urandom};
            if (nfree != 0) begin
               kind = $urandom_range(0, 2);
               if (k == cand) begin
                  // placement attempt, sized at or below the largest gap (one byte if there is no gap)
                  r.ext = 1'b0;
                  if (big == 0)
                     r.size = 31'd1;
                  else if ($urandom_range(0, 1) == 1)
                     r.size = big[pfa_pkg::SIZE_W-1:0];
                  else
                     r.size = 31'($urandom_range(1, 32'(big)));
               end else if (kind == 0 && nused != 0) begin
                  do pick = $urandom_range(0, pfa_pkg::SLOTS - 1); while (!slot_used[pick]);
                  r.tag = slot_tag[pick];
               end else if (kind == 1 && any_ext) begin
                  r.ext = 1'b1;
               end else if (big < longint'(SIZE_MAX)) begin
                  if ($urandom_range(0, 3) != 0) r.ext = 1'b0;
                  if ($urandom_range(0, 2) == 0)
                     r.size = big[pfa_pkg::SIZE_W-1:0] + 31'd1;
                  else
                     r.size = 31'($urandom_range(32'(big) + 1, 32'(SIZE_MAX)));
               end else if (any_ext) begin
                  r.ext = 1'b1;
               end
            end
            alloc_req_q = {alloc_req_q, r};
         end
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (errors == 0 && alloc_rsp_q.size() == 0)
         $display("tb_partition_fit_allocator OK");
      else
         $display("tb_partition_fit_allocator NOT OK");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_slot_store.sv
hw/rtl/pfa_fit_track.sv
hw/rtl/partition_fit_allocator.sv
tb/sv/tb_partition_fit_allocator.sv
